// ----- sv/bps_pkg.sv -----
// Shared types and constants of the byte pattern scanner.
`default_nettype none
package bps_pkg;

	localparam int NEEDLE_MAX      = 32;
	localparam int NEEDLE_WORDS    = 4;
	localparam int IDX_BITS        = $clog2(NEEDLE_MAX);
	localparam int LEN_BITS        = 6;
	localparam int OFFSET_BITS     = 40;
	localparam int HIT_OFFSET_BITS = 40;
	localparam int COUNT_BITS      = 16;
	localparam int CFG_DATA_BITS   = 64;
	localparam int CFG_INDEX_BITS  = 3;
	localparam int QDEPTH          = 4;
	localparam int QPTR_BITS       = $clog2(QDEPTH);
	localparam int QCNT_BITS       = $clog2(QDEPTH + 1);

	typedef enum logic [CFG_INDEX_BITS-1:0] {
		REG_NEEDLE_LENGTH  = 3'd0,
		REG_NEEDLE_BYTES_0 = 3'd1,
		REG_NEEDLE_BYTES_1 = 3'd2,
		REG_NEEDLE_BYTES_2 = 3'd3,
		REG_NEEDLE_BYTES_3 = 3'd4,
		REG_HIT_LIMIT      = 3'd5
	} bps_reg_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       region_first;
		logic       region_writable;
	} bps_in_t;

	typedef struct packed {
		logic [HIT_OFFSET_BITS-1:0] hit_offset;
		logic                       hit_writable;
		logic [COUNT_BITS-1:0]      writable_hits;
		logic                       limit_reached;
	} bps_out_t;

	typedef struct packed {
		logic [HIT_OFFSET_BITS-1:0] hit_offset;
		logic                       hit_writable;
	} bps_hit_t;

endpackage
`default_nettype wire

// ----- sv/bps_front.sv -----
// Front end: byte history, parallel needle compare and non-overlap skipping.
`default_nettype none
module bps_front import bps_pkg::*; (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         in_valid,
	output logic                              in_ready,
	input  wire bps_in_t                      in_data,
	input  wire logic [NEEDLE_MAX-1:0][7:0]   needle,
	input  wire logic [LEN_BITS-1:0]          needle_length,
	input  wire logic [QCNT_BITS-1:0]         queue_count,
	output logic                              push,
	output bps_hit_t                          push_data
);

	logic                       accept;
	logic [7:0]                 hist_q [NEEDLE_MAX];
	logic [LEN_BITS-1:0]        held_q;
	logic [LEN_BITS-1:0]        held_next;
	logic [OFFSET_BITS-1:0]     offset_q;
	logic [OFFSET_BITS-1:0]     cur;
	logic [IDX_BITS-1:0]        skip_q;
	logic [IDX_BITS-1:0]        skip_eff;
	logic [LEN_BITS-1:0]        len_eff;
	logic [7:0]                 aligned_d [NEEDLE_MAX];
	logic [NEEDLE_MAX-1:0]      mask_d;
	logic [7:0]                 aligned_q [NEEDLE_MAX];
	logic [NEEDLE_MAX-1:0]      mask_q;
	logic [LEN_BITS-1:0]        len_q;
	logic                       valid_s1;
	logic                       first_s1;
	logic                       writable_s1;
	logic [OFFSET_BITS-1:0]     cur_s1;
	logic                       match;

	// Room is reserved for the word already in the compare stage.
	assign in_ready = ({1'b0, queue_count} + QCNT_BITS'(valid_s1)) < (QCNT_BITS + 1)'(QDEPTH);
	assign accept   = in_valid && in_ready;

	assign len_eff = (needle_length > LEN_BITS'(NEEDLE_MAX)) ? LEN_BITS'(NEEDLE_MAX)
		: needle_length;

	// Needle reversed and aligned to the history, newest byte first.
	always_comb begin
		for (int k = 0; k < NEEDLE_MAX; k++) begin
			logic [LEN_BITS-1:0] diff;
			diff         = len_eff - LEN_BITS'(k + 1);
			aligned_d[k] = needle[diff[IDX_BITS-1:0]];
			mask_d[k]    = LEN_BITS'(k) < len_eff;
		end
	end

	assign cur = in_data.region_first ? '0 : offset_q;

	always_comb begin
		if (in_data.region_first) begin
			held_next = LEN_BITS'(1);
		end else if (held_q < LEN_BITS'(NEEDLE_MAX)) begin
			held_next = held_q + LEN_BITS'(1);
		end else begin
			held_next = held_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q   <= '0;
			offset_q <= '0;
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
			if (accept) begin
				held_q   <= held_next;
				offset_q <= cur + OFFSET_BITS'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < NEEDLE_MAX; k++) begin
			aligned_q[k] <= aligned_d[k];
		end
		mask_q <= mask_d;
		len_q  <= len_eff;
		if (accept) begin
			hist_q[0] <= in_data.data_byte;
			for (int k = 1; k < NEEDLE_MAX; k++) begin
				hist_q[k] <= hist_q[k-1];
			end
			first_s1    <= in_data.region_first;
			writable_s1 <= in_data.region_writable;
			cur_s1      <= cur;
		end
	end

	// The history already holds the word in this stage as its newest byte.
	always_comb begin
		match = (len_q != '0) && (held_q >= len_q);
		for (int k = 0; k < NEEDLE_MAX; k++) begin
			if (mask_q[k] && (hist_q[k] != aligned_q[k])) begin
				match = 1'b0;
			end
		end
	end

	assign skip_eff = first_s1 ? '0 : skip_q;
	assign push     = valid_s1 && (skip_eff == '0) && match;

	assign push_data.hit_offset   = HIT_OFFSET_BITS'(cur_s1 - OFFSET_BITS'(len_q)
		+ OFFSET_BITS'(1));
	assign push_data.hit_writable = writable_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skip_q <= '0;
		end else if (valid_s1) begin
			if (skip_eff != '0) begin
				skip_q <= skip_eff - IDX_BITS'(1);
			end else if (match) begin
				skip_q <= IDX_BITS'(len_q - LEN_BITS'(1));
			end else begin
				skip_q <= '0;
			end
		end
	end

endmodule
`default_nettype wire

// ----- sv/bps_fifo.sv -----
// Short hit queue between the compare front end and the counting back end.
`default_nettype none
module bps_fifo import bps_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  push,
	input  wire bps_hit_t              push_data,
	input  wire logic                  pop,
	output bps_hit_t                   head,
	output logic [QCNT_BITS-1:0]       count
);

	bps_hit_t               mem_q [QDEPTH];
	logic [QPTR_BITS-1:0]   wr_ptr_q;
	logic [QPTR_BITS-1:0]   rd_ptr_q;
	logic [QCNT_BITS-1:0]   count_q;

	assign head  = mem_q[rd_ptr_q];
	assign count = count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_BITS'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_BITS'(1);
			end
			count_q <= count_q + QCNT_BITS'(push) - QCNT_BITS'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (count_q < QCNT_BITS'(QDEPTH)))
		else $error("hit queue written while full");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> (count_q != '0))
		else $error("hit queue read while empty");

endmodule
`default_nettype wire

// ----- sv/bps_back.sv -----
// Back end: writable hit count, limit stop and the output register.
`default_nettype none
module bps_back import bps_pkg::*; (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic [QCNT_BITS-1:0]   queue_count,
	input  wire bps_hit_t               head,
	output logic                        pop,
	input  wire logic [COUNT_BITS-1:0]  hit_limit,
	output logic                        out_valid,
	input  wire logic                   out_ready,
	output bps_out_t                    out_data
);

	logic                   out_valid_q;
	bps_out_t               out_q;
	logic [COUNT_BITS-1:0]  total_q;
	logic [COUNT_BITS-1:0]  total_next;
	logic                   stopped_q;
	logic                   limit_hit;

	assign pop = (queue_count != '0) && (!out_valid_q || out_ready);

	assign total_next = (head.hit_writable && (total_q != '1)) ? total_q + COUNT_BITS'(1)
		: total_q;
	assign limit_hit  = head.hit_writable && (hit_limit != '0) && (total_next >= hit_limit);

	// Once stopped, queued hits are drained and dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			total_q     <= '0;
			stopped_q   <= 1'b0;
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (pop && !stopped_q) begin
				out_valid_q <= 1'b1;
				total_q     <= total_next;
				if (limit_hit) begin
					stopped_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && !stopped_q) begin
			out_q.hit_offset    <= head.hit_offset;
			out_q.hit_writable  <= head.hit_writable;
			out_q.writable_hits <= total_next;
			out_q.limit_reached <= limit_hit;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	a_stop_sticks: assert property (@(posedge clk) disable iff (!arst_n)
		stopped_q |=> stopped_q)
		else $error("scan restarted without reset");

	a_no_word_after_stop: assert property (@(posedge clk) disable iff (!arst_n)
		(stopped_q && !out_valid_q) |=> !out_valid_q)
		else $error("word produced after the scan stopped");

	a_limit_writable: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.limit_reached) |-> out_q.hit_writable)
		else $error("limit reported on a read-only hit");

endmodule
`default_nettype wire

// ----- sv/byte_pattern_scanner.sv -----
// Byte pattern scanner top level: configuration registers and the three stages.
//
// The scanner takes one byte word per cycle and reports each non-overlapping
// exact occurrence of the configured needle (1 to 32 bytes) within a region.
// Every accepted byte is compared against the whole needle at once in the
// compare stage; hits pass through a four-entry queue to the counting
// stage, whose output register holds a result word until it is taken. A hit
// is registered in the compare stage, written into the queue and loaded into
// the output register before it is offered. Bytes keep flowing at one per
// cycle while the result side keeps up; a stalled result side blocks input
// once the queued hits and the word in the compare stage together fill the
// queue. After the hit limit is reached no further words appear until reset.
// Configuration must be written through a plain write port while the scanner
// is idle, which the block does not enforce; it takes effect from the next cycle.
`default_nettype none
module byte_pattern_scanner import bps_pkg::*; (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       cfg_write,
	input  wire logic [CFG_INDEX_BITS-1:0]  cfg_index,
	input  wire logic [CFG_DATA_BITS-1:0]   cfg_data,
	input  wire logic                       in_valid,
	output logic                            in_ready,
	input  wire bps_in_t                    in_data,
	output logic                            out_valid,
	input  wire logic                       out_ready,
	output bps_out_t                        out_data
);

	logic [LEN_BITS-1:0]                          needle_length_q;
	logic [NEEDLE_WORDS-1:0][CFG_DATA_BITS-1:0]   needle_q;
	logic [COUNT_BITS-1:0]                        hit_limit_q;
	logic [NEEDLE_MAX-1:0][7:0]                   needle;
	logic                                         push;
	bps_hit_t                                     push_data;
	logic                                         pop;
	bps_hit_t                                     head;
	logic [QCNT_BITS-1:0]                         queue_count;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			needle_length_q <= LEN_BITS'(1);
			needle_q        <= '0;
			hit_limit_q     <= '0;
		end else if (cfg_write) begin
			unique case (bps_reg_t'(cfg_index))
				REG_NEEDLE_LENGTH:  needle_length_q <= cfg_data[LEN_BITS-1:0];
				REG_NEEDLE_BYTES_0: needle_q[0]     <= cfg_data;
				REG_NEEDLE_BYTES_1: needle_q[1]     <= cfg_data;
				REG_NEEDLE_BYTES_2: needle_q[2]     <= cfg_data;
				REG_NEEDLE_BYTES_3: needle_q[3]     <= cfg_data;
				REG_HIT_LIMIT:      hit_limit_q     <= cfg_data[COUNT_BITS-1:0];
				default: begin
				end
			endcase
		end
	end

	// Byte 0 of the needle sits in the lowest bits of the first word.
	assign needle = needle_q;

	bps_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.in_data       (in_data),
		.needle        (needle),
		.needle_length (needle_length_q),
		.queue_count   (queue_count),
		.push          (push),
		.push_data     (push_data)
	);

	bps_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.head      (head),
		.count     (queue_count)
	);

	bps_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.queue_count (queue_count),
		.head        (head),
		.pop         (pop),
		.hit_limit   (hit_limit_q),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_data    (out_data)
	);

endmodule
`default_nettype wire

// ----- test/byte_pattern_scanner_checker.sv -----
// Checker for the byte pattern scanner: predicts each hit word and compares the result channel.
module byte_pattern_scanner_checker import bps_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_write,
	input  logic [CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [CFG_DATA_BITS-1:0]  cfg_data,
	input  logic                      in_valid,
	input  logic                      in_ready,
	input  bps_in_t                   in_data,
	input  logic                      out_valid,
	input  logic                      out_ready,
	input  bps_out_t                  out_data,
	output int                        errors,
	output int                        pending
);

	logic [LEN_BITS-1:0]    cfg_len;
	logic [63:0]            cfg_needle [NEEDLE_WORDS];
	logic [COUNT_BITS-1:0]  cfg_limit;

	logic [7:0]             recent [NEEDLE_MAX];
	int                     held;
	logic [OFFSET_BITS-1:0] next_offset;
	logic [4:0]             skip_left;
	logic [COUNT_BITS-1:0]  writable_total;
	bit                     halted;

	bps_out_t               hits_due [$];
	bps_out_t               due;

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		if (errors < 40) begin
			$display("%0t scanner %s: got %0h, expected %0h", $time, what, got, want);
		end
		errors++;
	endtask

	function automatic logic [7:0] needle_at(input int i);
		return cfg_needle[i / 8][8 * (i % 8) +: 8];
	endfunction

	// Works out the hit word, if any, that one accepted byte word causes.
	function automatic void scan_byte(input bps_in_t w);
		int                     eff;
		bit                     hit;
		logic [OFFSET_BITS-1:0] cur;
		bps_out_t               word;
		if (halted) begin
			return;
		end
		if (w.region_first) begin
			held = 0;
			next_offset = '0;
			skip_left = '0;
		end
		cur = next_offset;
		next_offset = next_offset + 1'b1;
		for (int i = NEEDLE_MAX - 1; i > 0; i--) begin
			recent[i] = recent[i - 1];
		end
		recent[0] = w.data_byte;
		if (held < NEEDLE_MAX) begin
			held++;
		end
		eff = (cfg_len > NEEDLE_MAX) ? NEEDLE_MAX : int'(cfg_len);
		if (skip_left != 0) begin
			skip_left--;
			return;
		end
		hit = (eff != 0) && (held >= eff);
		for (int i = 0; i < eff; i++) begin
			if (recent[eff - 1 - i] != needle_at(i)) begin
				hit = 1'b0;
			end
		end
		if (!hit) begin
			return;
		end
		skip_left = 5'(eff - 1);
		word.limit_reached = 1'b0;
		if (w.region_writable) begin
			if (writable_total != '1) begin
				writable_total++;
			end
			if (cfg_limit != 0 && writable_total >= cfg_limit) begin
				word.limit_reached = 1'b1;
				halted = 1'b1;
			end
		end
		word.hit_offset = cur - OFFSET_BITS'(eff - 1);
		word.hit_writable = w.region_writable;
		word.writable_hits = writable_total;
		hits_due = {hits_due, word};
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			errors = 0;
			cfg_len = 6'd1;
			cfg_needle = '{default: '0};
			cfg_limit = '0;
			recent = '{default: '0};
			held = 0;
			next_offset = '0;
			skip_left = '0;
			writable_total = '0;
			halted = 1'b0;
			hits_due.delete();
			pending <= 0;
		end else begin
			if (out_valid && out_ready) begin
				if (hits_due.size() == 0) begin
					report_mismatch("result word with nothing due", 64'(out_data), '0);
				end else begin
					due = hits_due.pop_front();
					if (out_data.hit_offset !== due.hit_offset) begin
						report_mismatch("hit_offset", 64'(out_data.hit_offset),
							64'(due.hit_offset));
					end
					if (out_data.hit_writable !== due.hit_writable) begin
						report_mismatch("hit_writable", 64'(out_data.hit_writable),
							64'(due.hit_writable));
					end
					if (out_data.writable_hits !== due.writable_hits) begin
						report_mismatch("writable_hits", 64'(out_data.writable_hits),
							64'(due.writable_hits));
					end
					if (out_data.limit_reached !== due.limit_reached) begin
						report_mismatch("limit_reached", 64'(out_data.limit_reached),
							64'(due.limit_reached));
					end
				end
			end
			if (cfg_write) begin
				case (bps_reg_t'(cfg_index))
					REG_NEEDLE_LENGTH: begin
						cfg_len = cfg_data[LEN_BITS-1:0];
					end
					REG_NEEDLE_BYTES_0: begin
						cfg_needle[0] = cfg_data;
					end
					REG_NEEDLE_BYTES_1: begin
						cfg_needle[1] = cfg_data;
					end
					REG_NEEDLE_BYTES_2: begin
						cfg_needle[2] = cfg_data;
					end
					REG_NEEDLE_BYTES_3: begin
						cfg_needle[3] = cfg_data;
					end
					REG_HIT_LIMIT: begin
						cfg_limit = cfg_data[COUNT_BITS-1:0];
					end
					default: begin
					end
				endcase
			end
			if (in_valid && in_ready) begin
				scan_byte(in_data);
			end
			pending <= hits_due.size();
		end
	end

endmodule

// ----- test/byte_pattern_scanner_tb.sv -----
// Testbench top for the byte pattern scanner: clock, reset, stimulus and verdict.
module byte_pattern_scanner_tb;
	import bps_pkg::*;

	logic                      clk = 1'b0;
	logic                      arst_n = 1'b0;
	logic                      cfg_write = 1'b0;
	logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
	logic [CFG_DATA_BITS-1:0]  cfg_data = '0;
	logic                      in_valid = 1'b0;
	logic                      in_ready;
	bps_in_t                   in_data = '0;
	logic                      out_valid;
	logic                      out_ready = 1'b0;
	bps_out_t                  out_data;

	int                        mismatches;
	int                        words_due;
	int                        src_idle = 21;
	int                        sink_idle = 66;

	// Copy of the needle as last written, used to build matching streams.
	logic [LEN_BITS-1:0]       needle_len = 6'd1;
	logic [63:0]               needle_word [NEEDLE_WORDS] = '{default: '0};
	bit                        region_w = 1'b1;

	byte_pattern_scanner u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	byte_pattern_scanner_checker u_check (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.errors    (mismatches),
		.pending   (words_due)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= sink_idle);
	end

	initial begin
		#30_000_000;
		$display("CHECK FAILED");
		$finish;
	end

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	function automatic logic [7:0] needle_at(input int i);
		return needle_word[i / 8][8 * (i % 8) +: 8];
	endfunction

	// Offers one byte word and returns at the edge that accepts it.
	task automatic push_byte(input logic [7:0] b, input logic f, input logic w);
		while ($urandom_range(99) < src_idle) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= '{data_byte: b, region_first: f, region_writable: w};
		do @(posedge clk); while (!in_ready);
	endtask

	// Holds the input back until every predicted hit has come out, then lets
	// the pipeline settle. Returns on a rising edge.
	task automatic drain();
		in_valid <= 1'b0;
		do @(negedge clk); while (words_due != 0);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(input bps_reg_t r, input logic [63:0] v);
		cfg_write <= 1'b1;
		cfg_index <= r;
		cfg_data <= v;
		@(posedge clk);
	endtask

	task automatic load_needle(input logic [LEN_BITS-1:0] len, input logic [63:0] w0,
			input logic [63:0] w1, input logic [63:0] w2, input logic [63:0] w3,
			input logic [COUNT_BITS-1:0] limit);
		needle_len = len;
		needle_word = '{w0, w1, w2, w3};
		write_reg(REG_NEEDLE_LENGTH, 64'(len));
		write_reg(REG_NEEDLE_BYTES_0, w0);
		write_reg(REG_NEEDLE_BYTES_1, w1);
		write_reg(REG_NEEDLE_BYTES_2, w2);
		write_reg(REG_NEEDLE_BYTES_3, w3);
		write_reg(REG_HIT_LIMIT, 64'(limit));
		cfg_write <= 1'b0;
	endtask

	// Mostly whole needle copies in random surroundings, with cut or corrupted
	// copies, near misses and region starts that break a copy in two.
	task automatic run_scan(input int count);
		logic [7:0] plan [$];
		int         eff;
		int         r;
		int         k;
		bit         fresh;
		bit         first;
		bit         w;
		eff = (needle_len > NEEDLE_MAX) ? NEEDLE_MAX : int'(needle_len);
		for (int n = 0; n < count; n++) begin
			fresh = (plan.size() == 0);
			if (fresh) begin
				r = $urandom_range(99);
				if (eff != 0 && r < 55) begin
					for (int i = 0; i < eff; i++) plan = {plan, needle_at(i)};
				end else if (eff != 0 && r < 70) begin
					k = $urandom_range(eff - 1);
					if (r < 62) begin
						for (int i = 0; i <= k; i++) plan = {plan, needle_at(i)};
					end else begin
						for (int i = 0; i < eff; i++) plan = {plan, needle_at(i)};
						plan[k] = plan[k] ^ (8'h01 << $urandom_range(7));
					end
				end else begin
					repeat ($urandom_range(1, 8)) begin
						plan = {plan, (($urandom_range(3) == 0) ?
							needle_at($urandom_range(NEEDLE_MAX - 1)) :
							8'($urandom_range(255)))};
					end
				end
			end
			first = (fresh && $urandom_range(9) == 0) || ($urandom_range(199) == 0);
			if (first) begin
				region_w = 1'($urandom_range(1));
			end
			w = ($urandom_range(99) < 5) ? !region_w : region_w;
			push_byte(plan.pop_front(), first, w);
			if ($urandom_range(399) == 0) begin
				drain();
			end
		end
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset needle is one zero byte; the stream starts without a region start.
		push_byte(8'h00, 1'b0, 1'b1);
		push_byte(8'hFF, 1'b0, 1'b0);
		push_byte(8'h00, 1'b0, 1'b0);
		drain();
		// A zero length needle never matches.
		load_needle(6'd0, '0, '0, '0, '0, 16'd0);
		push_byte(8'h00, 1'b1, 1'b1);
		push_byte(8'h00, 1'b0, 1'b1);
		drain();
		// Repeated bytes: hits must not overlap, and a region start cuts the run.
		load_needle(6'd2, 64'h5A5A, '1, '1, '1, 16'hFFFF);
		push_byte(8'h5A, 1'b1, 1'b1);
		push_byte(8'h5A, 1'b0, 1'b1);
		push_byte(8'h5A, 1'b0, 1'b1);
		push_byte(8'h5A, 1'b0, 1'b0);
		push_byte(8'h5A, 1'b1, 1'b1);
		push_byte(8'h5A, 1'b0, 1'b0);
		push_byte(8'h5A, 1'b0, 1'b1);
		drain();

		load_needle(6'd1, rand64(), rand64(), rand64(), rand64(), 16'd0);
		run_scan(195);
		drain();
		load_needle(6'd32, rand64(), rand64(), rand64(), rand64(), 16'hFFFF);
		run_scan(195);
		drain();
		load_needle(6'd0, rand64(), rand64(), rand64(), rand64(), 16'd0);
		run_scan(195);
		drain();

		src_idle = 66;
		sink_idle = 21;
		load_needle(6'd2, '1, '1, '1, '1, 16'($urandom_range(30000, 65535)));
		run_scan(195);
		drain();
		// Lengths beyond the needle store behave as the full 32 bytes.
		load_needle(6'd63, rand64(), rand64(), rand64(), rand64(), 16'd0);
		run_scan(195);
		drain();
		load_needle(6'($urandom_range(3, 31)), rand64(), rand64(), rand64(), rand64(),
			16'hFFFF);
		run_scan(195);
		drain();

		src_idle = 0;
		sink_idle = 0;
		load_needle(6'd33, rand64(), rand64(), rand64(), rand64(), 16'd0);
		run_scan(195);
		drain();
		load_needle(6'($urandom_range(3, 8)), rand64(), '0, '0, '0,
			16'($urandom_range(30000, 65535)));
		run_scan(195);
		drain();
		load_needle(6'd1, '0, rand64(), rand64(), rand64(), 16'd0);
		run_scan(195);
		drain();

		// Every byte a writable hit, lifting the count well past the next limit.
		load_needle(6'd1, 64'hA5, '0, '0, '0, 16'd0);
		push_byte(8'hA5, 1'b1, 1'b1);
		repeat (20) push_byte(8'hA5, 1'b0, 1'b1);
		drain();
		// Limit now below the count: read-only hits pass, the next writable one stops.
		load_needle(6'd1, 64'hA5, '0, '0, '0, 16'd7);
		push_byte(8'hA5, 1'b1, 1'b0);
		push_byte(8'hA5, 1'b0, 1'b0);
		push_byte(8'hA5, 1'b0, 1'b0);
		push_byte(8'hA5, 1'b0, 1'b1);
		repeat (10) push_byte(($urandom_range(1) != 0) ? 8'hA5 : 8'($urandom_range(255)),
			1'b0, 1'($urandom_range(1)));
		drain();
		// Once stopped, new settings must not bring the scan back.
		load_needle(6'd1, 64'h00, '0, '0, '0, 16'd0);
		repeat (8) push_byte(8'h00, 1'b0, 1'b1);
		drain();

		if (mismatches == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
